// ----- rtl/gld_pkg.sv -----
// shared types, constants and helpers of the gif lzw decoder
package gld_pkg;

   localparam int GLD_MAX_CODE_BITS = 12;
   localparam logic [3:0] GLD_MIN_CODE_RESET = 4'd8;

   localparam logic [2:0] ST_BYTE_TAKEN   = 3'd0;
   localparam logic [2:0] ST_BYTE_REFUSED = 3'd1;
   localparam logic [2:0] ST_PIXEL        = 3'd2;
   localparam logic [2:0] ST_NEED_DATA    = 3'd3;
   localparam logic [2:0] ST_CLEAR_SEEN   = 3'd4;
   localparam logic [2:0] ST_ENDED        = 3'd5;
   localparam logic [2:0] ST_BAD_CODE     = 3'd6;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_PULL = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } gld_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] pixel_index;
      logic       string_last;
   } gld_rsp_type;

   // clamp of the minimum code size register
   function automatic logic [3:0] gld_eff_min(input logic [3:0] raw, input logic [3:0] cap);
      logic [3:0] m;
      m = raw;
      if (m < 4'd2) m = 4'd2;
      if (m > 4'd8) m = 4'd8;
      if (m > cap) m = cap;
      return m;
   endfunction

endpackage

// ----- rtl/gld_dict.sv -----
// dictionary memory: prefix and suffix of each code, registered read
module gld_dict #(
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ADDR_W-1:0] wr_prefix,
   input  logic [7:0]        wr_suffix,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ADDR_W-1:0] rd_prefix,
   output logic [7:0]        rd_suffix
);
   localparam int DEPTH = 1 << ADDR_W;

   logic [ADDR_W-1:0] prefix_mem [DEPTH];
   logic [7:0]        suffix_mem [DEPTH];
   logic [ADDR_W-1:0] rd_prefix_ff;
   logic [7:0]        rd_suffix_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prefix_mem[wr_addr] <= wr_prefix;
         suffix_mem[wr_addr] <= wr_suffix;
      end
      rd_prefix_ff <= prefix_mem[rd_addr];
      rd_suffix_ff <= suffix_mem[rd_addr];
   end

   assign rd_prefix = rd_prefix_ff;
   assign rd_suffix = rd_suffix_ff;
endmodule

// ----- rtl/gld_stack.sv -----
// pixel stack memory, one write and one registered read port
module gld_stack #(
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   localparam int DEPTH = 1 << ADDR_W;

   logic [7:0] stack_mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/gif_lzw_decoder_top.sv -----
// gif lzw decoder: bit buffer, code sequencer, dictionary and pixel stack
// A push word is answered in the cycle after it is taken. A pull that finds
// pixels on the stack, or whose code is a literal, a clear, the end code or
// bad, is answered from S_PULL. A code that expands through the dictionary
// goes S_LOOKUP, then S_STEP per link walked, then S_LIT: the single
// dictionary read port follows one prefix link per cycle and pushes one
// pixel onto the stack; the rest of that string then comes out one per pull.
// The stores start undefined, so there is no clearing pass after reset.
module gif_lzw_decoder_top #(
   parameter int MAX_CODE_BITS = gld_pkg::GLD_MAX_CODE_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gld_pkg::gld_req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gld_pkg::gld_rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_data
);
   import gld_pkg::*;

   localparam int CW = MAX_CODE_BITS;
   localparam int LW = MAX_CODE_BITS + 1;
   localparam logic [3:0] CW_MAX = 4'(MAX_CODE_BITS);
   localparam logic [3:0] MIN_CAP = 4'(MAX_CODE_BITS - 1);
   localparam logic [3:0] RESET_EFF = gld_eff_min(GLD_MIN_CODE_RESET, MIN_CAP);

   typedef enum logic [2:0] {
      S_IDLE, S_PULL, S_LOOKUP, S_STEP, S_LIT
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  min_ff, min_in;
   logic [23:0] buf_ff, buf_in;
   logic [4:0]  bits_ff, bits_in;
   logic [3:0]  cw_ff, cw_in;
   logic [LW-1:0] nfc_ff, nfc_in;
   logic [CW-1:0] prev_ff, prev_in;
   logic [7:0]  pfp_ff, pfp_in;
   logic        after_clear_ff, after_clear_in;
   logic        ended_ff, ended_in;
   logic [LW-1:0] level_ff, level_in;
   logic [CW-1:0] code_ff, code_in;
   logic [CW-1:0] link_ff, link_in;
   logic        add_ff, add_in;
   logic        rsp_valid_ff, rsp_valid_in;
   gld_rsp_type rsp_data_ff, rsp_data_in;

   logic        req_acc, csr_acc, out_free;
   logic [3:0]  eff, eff_new;
   logic [LW-1:0] clear_code, clear2, code_x, nfc_plus;
   logic [CW-1:0] code;
   logic        do_add;
   logic [CW-1:0] add_pre;
   logic [7:0]  add_suf;
   logic        dict_we;
   logic [CW-1:0] dict_rd_addr, dict_pre;
   logic [7:0]  dict_suf;
   logic        st_we;
   logic [7:0]  st_rd;

   assign req_acc  = req_valid && !req_stall;
   assign csr_acc  = csr_valid && csr_ready;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free || csr_valid;
   assign csr_ready = (state_ff == S_IDLE);

   assign eff        = gld_eff_min(min_ff, MIN_CAP);
   assign eff_new    = gld_eff_min(csr_data, MIN_CAP);
   assign clear_code = LW'(1) << eff;
   assign clear2     = clear_code + LW'(2);
   assign code       = buf_ff[CW-1:0] & ~({CW{1'b1}} << cw_ff);
   assign code_x     = {1'b0, code};
   assign nfc_plus   = nfc_ff + LW'(1);

   assign dict_we      = do_add && !nfc_ff[CW];
   assign dict_rd_addr = (state_ff == S_STEP) ? dict_pre : link_ff;

   gld_dict #(.ADDR_W(CW)) u_dict (
      .clock     (clock),
      .wr_en     (dict_we),
      .wr_addr   (nfc_ff[CW-1:0]),
      .wr_prefix (add_pre),
      .wr_suffix (add_suf),
      .rd_addr   (dict_rd_addr),
      .rd_prefix (dict_pre),
      .rd_suffix (dict_suf)
   );

   gld_stack #(.ADDR_W(CW)) u_stack (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (level_ff[CW-1:0]),
      .wr_data (dict_suf),
      .rd_addr (CW'(level_ff - LW'(1))),
      .rd_data (st_rd)
   );

   always_comb begin
      state_in       = state_ff;
      min_in         = min_ff;
      buf_in         = buf_ff;
      bits_in        = bits_ff;
      cw_in          = cw_ff;
      nfc_in         = nfc_ff;
      prev_in        = prev_ff;
      pfp_in         = pfp_ff;
      after_clear_in = after_clear_ff;
      ended_in       = ended_ff;
      level_in       = level_ff;
      code_in        = code_ff;
      link_in        = link_ff;
      add_in         = add_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      do_add         = 1'b0;
      add_pre        = prev_ff;
      add_suf        = pfp_ff;
      st_we          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_data.req_type == REQ_PUSH) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  if (bits_ff > 5'd16) begin
                     rsp_data_in.status = ST_BYTE_REFUSED;
                  end else begin
                     buf_in  = buf_ff | (24'(req_data.data_byte) << bits_ff);
                     bits_in = bits_ff + 5'd8;
                     rsp_data_in.status = ST_BYTE_TAKEN;
                  end
               end else begin
                  state_in = S_PULL;
               end
            end
         end
         S_PULL: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (level_ff != '0) begin
                  rsp_data_in.status      = ST_PIXEL;
                  rsp_data_in.pixel_index = st_rd;
                  rsp_data_in.string_last = (level_ff == LW'(1));
                  level_in = level_ff - LW'(1);
               end else if (ended_ff) begin
                  rsp_data_in.status = ST_ENDED;
               end else if (bits_ff < {1'b0, cw_ff}) begin
                  rsp_data_in.status = ST_NEED_DATA;
               end else begin
                  buf_in  = buf_ff >> cw_ff;
                  bits_in = bits_ff - 5'(cw_ff);
                  if (code_x == clear_code) begin
                     cw_in          = eff + 4'd1;
                     nfc_in         = clear2;
                     after_clear_in = 1'b1;
                     rsp_data_in.status = ST_CLEAR_SEEN;
                  end else if (code_x == clear_code + LW'(1)) begin
                     ended_in = 1'b1;
                     rsp_data_in.status = ST_ENDED;
                  end else if (after_clear_ff) begin
                     if (code_x >= clear_code) begin
                        rsp_data_in.status = ST_BAD_CODE;
                     end else begin
                        after_clear_in = 1'b0;
                        prev_in        = code;
                        pfp_in         = code[7:0];
                        rsp_data_in.status      = ST_PIXEL;
                        rsp_data_in.pixel_index = code[7:0];
                        rsp_data_in.string_last = 1'b1;
                     end
                  end else if (code_x > nfc_ff) begin
                     rsp_data_in.status = ST_BAD_CODE;
                  end else if (code_x == nfc_ff) begin
                     // code not yet in the table: entry from previous code first
                     if (nfc_ff[CW]) begin
                        rsp_data_in.status = ST_BAD_CODE;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && rsp_stall;
                        do_add   = 1'b1;
                        link_in  = code;
                        code_in  = code;
                        add_in   = 1'b0;
                        state_in = S_LOOKUP;
                     end
                  end else if (code_x < clear2) begin
                     do_add  = 1'b1;
                     add_suf = code[7:0];
                     prev_in = code;
                     pfp_in  = code[7:0];
                     rsp_data_in.status      = ST_PIXEL;
                     rsp_data_in.pixel_index = code[7:0];
                     rsp_data_in.string_last = 1'b1;
                  end else begin
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                     link_in  = code;
                     code_in  = code;
                     add_in   = 1'b1;
                     state_in = S_LOOKUP;
                  end
               end
            end
         end
         S_LOOKUP: begin
            state_in = S_STEP;
         end
         S_STEP: begin
            // one prefix link per cycle, suffix goes onto the stack
            st_we    = 1'b1;
            level_in = level_ff + LW'(1);
            link_in  = dict_pre;
            if ({1'b0, dict_pre} < clear2) begin
               state_in = S_LIT;
            end
         end
         S_LIT: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_data_in.status      = ST_PIXEL;
            rsp_data_in.pixel_index = link_ff[7:0];
            rsp_data_in.string_last = (level_ff == '0);
            if (add_ff) begin
               do_add  = 1'b1;
               add_suf = link_ff[7:0];
            end
            prev_in = code_ff;
            pfp_in  = link_ff[7:0];
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_add && !nfc_ff[CW]) begin
         nfc_in = nfc_plus;
         if ((nfc_plus == (LW'(1) << cw_ff)) && (cw_ff < CW_MAX)) begin
            cw_in = cw_ff + 4'd1;
         end
      end

      if (csr_acc) begin
         state_in       = S_IDLE;
         min_in         = csr_data;
         buf_in         = '0;
         bits_in        = '0;
         prev_in        = '0;
         pfp_in         = '0;
         ended_in       = 1'b0;
         level_in       = '0;
         cw_in          = eff_new + 4'd1;
         nfc_in         = (LW'(1) << eff_new) + LW'(2);
         after_clear_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         min_ff         <= GLD_MIN_CODE_RESET;
         buf_ff         <= '0;
         bits_ff        <= '0;
         cw_ff          <= RESET_EFF + 4'd1;
         nfc_ff         <= (LW'(1) << RESET_EFF) + LW'(2);
         prev_ff        <= '0;
         pfp_ff         <= '0;
         after_clear_ff <= 1'b1;
         ended_ff       <= 1'b0;
         level_ff       <= '0;
         add_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         min_ff         <= min_in;
         buf_ff         <= buf_in;
         bits_ff        <= bits_in;
         cw_ff          <= cw_in;
         nfc_ff         <= nfc_in;
         prev_ff        <= prev_in;
         pfp_ff         <= pfp_in;
         after_clear_ff <= after_clear_in;
         ended_ff       <= ended_in;
         level_ff       <= level_in;
         add_ff         <= add_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      code_ff     <= code_in;
      link_ff     <= link_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_last_empties_stack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.string_last |-> level_ff == '0)
      else $error("string end shown while pixels remain on the stack");

   a_dict_bound: assert property (@(posedge clock) disable iff (reset)
      nfc_ff <= (LW'(1) << CW))
      else $error("next free code beyond the dictionary");

   a_width_bound: assert property (@(posedge clock) disable iff (reset)
      cw_ff >= 4'd3 && cw_ff <= CW_MAX)
      else $error("code width out of range");
endmodule
